[design/mtcd_pkg.sv]
// ----------------------------------------------------------------------------
// Millisecond timestamp to calendar date: shared definitions
// Pipeline depth, stage enable type and the reciprocal constants that
// replace the constant divisions of the conversion.
// ----------------------------------------------------------------------------
package mtcd_pkg;

  localparam int unsigned NUM_STAGES = 10;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Latest representable instant, 9999-12-31 23:59:59.999.
  localparam logic [47:0] MAX_MILLIS = 48'd253402300799999;

  localparam logic [26:0] MS_PER_DAY = 27'd86400000;

  // Day estimate: floor(t[47:16] * DAY_RECIP / 2**32) is at most two below t / MS_PER_DAY.
  localparam logic [21:0] DAY_RECIP = 22'((64'd1 << 48) / 64'd86400000);

  // Exact reciprocals: floor(x * R / 2**S) equals x / D over the whole input range.
  localparam logic [27:0] SEC_RECIP  = 28'(((64'd1 << 37) + 64'd999) / 64'd1000);
  localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [23:0] A_RECIP    = 24'(((64'd1 << 41) + 64'd146096) / 64'd146097);
  localparam logic [27:0] C_RECIP    = 28'(((64'd1 << 40) + 64'd7304) / 64'd7305);
  localparam logic [29:0] E_RECIP    =
    30'(64'd1000 * (((64'd1 << 34) + 64'd30600) / 64'd30601));
  localparam logic [22:0] WD_RECIP   = 23'(((64'd1 << 25) + 64'd6) / 64'd7);

endpackage

[design/millis_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// Millisecond timestamp to calendar date
// Converts milliseconds since 1970-01-01 UTC into Gregorian date, weekday
// and time of day.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one timestamp per word; values past the end of
// year 9999 are clamped to 9999-12-31 23:59:59.999. The output channel returns
// one word per timestamp, in order, with year, month, day, weekday (Monday is
// one, Sunday is seven), hour, minute, second and millisecond.
// The block is a ten-stage pipeline that takes a word in every cycle while no
// stall has backed up to its input. The depth is set by the chain of reciprocal
// multiplications that split the day count and the time of day, each followed
// by a register. Every stage holds its own valid bit, so empty stages close up
// behind a stalled output word and the input keeps accepting until all ten
// stages are full. A stall never drops or repeats a word.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module millis_to_calendar_date
  import mtcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // unix_millis[47:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // year[13:0], month[17:14], day_of_month[22:18], weekday[25:23], hour[30:26],
  // minute[36:31], second[42:37], millis[52:43], zero fill[55:53]
  output logic [55:0] out_tdata
);

  stage_en_t           en;
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_src;

  logic [47:0] t1_nxt, t1_r;

  logic [53:0] day_prod;
  logic [21:0] qe2_r;
  logic [27:0] tlo2_r;

  logic [48:0] back_prod;
  logic [27:0] rem3_nxt, rem3_r;
  logic [21:0] qe3_r;

  logic [21:0] days4_nxt, days4_r;
  logic [26:0] msd4_nxt, msd4_r;

  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [9:0]  millis;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign vld_src   = {vld_r[NUM_STAGES-2:0], in_tvalid};
  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_src[i];
        end
      end
    end
  end

  always_comb begin
    t1_nxt    = (in_tdata > MAX_MILLIS) ? MAX_MILLIS : in_tdata;
    day_prod  = 54'(t1_r[47:16]) * 54'(DAY_RECIP);
    back_prod = 49'(qe2_r) * 49'(MS_PER_DAY);
    rem3_nxt  = tlo2_r - back_prod[27:0];
    // The day estimate is short by zero, one or two days.
    priority if (rem3_r >= 28'({MS_PER_DAY, 1'b0})) begin
      days4_nxt = qe3_r + 22'd2;
      msd4_nxt  = 27'(rem3_r - 28'({MS_PER_DAY, 1'b0}));
    end else if (rem3_r >= 28'(MS_PER_DAY)) begin
      days4_nxt = qe3_r + 22'd1;
      msd4_nxt  = 27'(rem3_r - 28'(MS_PER_DAY));
    end else begin
      days4_nxt = qe3_r;
      msd4_nxt  = rem3_r[26:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1_r <= t1_nxt;
    end
    if (en[1]) begin
      qe2_r  <= day_prod[53:32];
      tlo2_r <= t1_r[27:0];
    end
    if (en[2]) begin
      rem3_r <= rem3_nxt;
      qe3_r  <= qe2_r;
    end
    if (en[3]) begin
      days4_r <= days4_nxt;
      msd4_r  <= msd4_nxt;
    end
  end

  mtcd_date u_date (
    .clk          (clk),
    .en           (en),
    .days         (days4_r),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday)
  );

  mtcd_tod u_tod (
    .clk       (clk),
    .en        (en),
    .ms_of_day (msd4_r),
    .hour      (hour),
    .minute    (minute),
    .second    (second),
    .millis    (millis)
  );

  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tdata  = {3'b000, millis, second, minute, hour, weekday, day_of_month,
                       month, year};

endmodule

[design/mtcd_tod.sv]
// ----------------------------------------------------------------------------
// Time of day
// Splits the milliseconds of one day into hour, minute, second and
// millisecond over stages five to ten of the pipeline.
// ----------------------------------------------------------------------------
module mtcd_tod
  import mtcd_pkg::*;
(
  input  logic        clk,
  input  stage_en_t   en,
  input  logic [26:0] ms_of_day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [9:0]  millis
);

  logic [54:0] sec_prod;
  logic [16:0] secs5_nxt, secs5_r;
  logic [26:0] msd5_r;

  logic [34:0] hour_prod;
  logic [26:0] ms_diff;
  logic [16:0] secs6_r;
  logic [4:0]  hr6_nxt, hr6_r;
  logic [9:0]  ms6_nxt, ms6_r;

  logic [16:0] rs_diff;
  logic [11:0] rs7_nxt, rs7_r;
  logic [4:0]  hr7_r;
  logic [9:0]  ms7_r;

  logic [24:0] min_prod;
  logic [5:0]  mn8_nxt, mn8_r;
  logic [11:0] rs8_r;
  logic [4:0]  hr8_r;
  logic [9:0]  ms8_r;

  logic [11:0] sec_diff;
  logic [5:0]  sec9_nxt, sec9_r;
  logic [5:0]  mn9_r;
  logic [4:0]  hr9_r;
  logic [9:0]  ms9_r;

  logic [4:0]  hr10_r;
  logic [5:0]  mn10_r;
  logic [5:0]  sec10_r;
  logic [9:0]  ms10_r;

  always_comb begin
    sec_prod  = 55'(ms_of_day) * 55'(SEC_RECIP);
    secs5_nxt = sec_prod[53:37];

    ms_diff   = msd5_r - 27'(27'(secs5_r) * 27'd1000);
    ms6_nxt   = ms_diff[9:0];
    hour_prod = 35'(secs5_r) * 35'(HOUR_RECIP);
    hr6_nxt   = hour_prod[33:29];

    rs_diff   = secs6_r - 17'(17'(hr6_r) * 17'd3600);
    rs7_nxt   = rs_diff[11:0];

    min_prod  = 25'(rs7_r) * 25'(MIN_RECIP);
    mn8_nxt   = min_prod[23:18];

    sec_diff  = rs8_r - 12'(12'(mn8_r) * 12'd60);
    sec9_nxt  = sec_diff[5:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      secs5_r <= secs5_nxt;
      msd5_r  <= ms_of_day;
    end
    if (en[5]) begin
      secs6_r <= secs5_r;
      hr6_r   <= hr6_nxt;
      ms6_r   <= ms6_nxt;
    end
    if (en[6]) begin
      rs7_r <= rs7_nxt;
      hr7_r <= hr6_r;
      ms7_r <= ms6_r;
    end
    if (en[7]) begin
      mn8_r <= mn8_nxt;
      rs8_r <= rs7_r;
      hr8_r <= hr7_r;
      ms8_r <= ms7_r;
    end
    if (en[8]) begin
      sec9_r <= sec9_nxt;
      mn9_r  <= mn8_r;
      hr9_r  <= hr8_r;
      ms9_r  <= ms8_r;
    end
    if (en[9]) begin
      sec10_r <= sec9_r;
      mn10_r  <= mn9_r;
      hr10_r  <= hr9_r;
      ms10_r  <= ms9_r;
    end
  end

  assign hour   = hr10_r;
  assign minute = mn10_r;
  assign second = sec10_r;
  assign millis = ms10_r;

endmodule

[design/mtcd_date.sv]
// ----------------------------------------------------------------------------
// Calendar date
// Turns a day count since the epoch into year, month, day of month and
// weekday by the Julian-day integer method, over stages five to ten.
// ----------------------------------------------------------------------------
module mtcd_date
  import mtcd_pkg::*;
(
  input  logic        clk,
  input  stage_en_t   en,
  input  logic [21:0] days,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [2:0]  weekday
);

  // Integer part of 601 * e / 1000 for the month index e.
  function automatic logic [3:0] month_frac(input logic [3:0] e);
    logic [3:0] v;
    unique case (e)
      4'd0, 4'd1:   v = 4'd0;
      4'd2, 4'd3:   v = 4'd1;
      4'd4:         v = 4'd2;
      4'd5, 4'd6:   v = 4'd3;
      4'd7, 4'd8:   v = 4'd4;
      4'd9:         v = 4'd5;
      4'd10, 4'd11: v = 4'd6;
      4'd12, 4'd13: v = 4'd7;
      4'd14:        v = 4'd8;
      default:      v = 4'd9;
    endcase
    return v;
  endfunction

  logic [23:0] a_num;
  logic [47:0] a_prod;
  logic [6:0]  a5_nxt, a5_r;
  logic [22:0] wd_num;
  logic [44:0] wd_prod;
  logic [2:0]  wq5_r;
  logic [2:0]  wn5_r;
  logic [21:0] days5_r;

  logic [22:0] b6_nxt, b6_r;
  logic [2:0]  wd6_nxt, wd6_r;

  logic [26:0] c_num;
  logic [54:0] c_prod;
  logic [13:0] c7_nxt, c7_r;
  logic [22:0] b7_r;
  logic [2:0]  wd7_r;

  logic [22:0] d_diff;
  logic [8:0]  d8_nxt, d8_r;
  logic [13:0] c8_r;
  logic [2:0]  wd8_r;

  logic [38:0] e_prod;
  logic [3:0]  e9_nxt, e9_r;
  logic [8:0]  d9_r;
  logic [13:0] c9_r;
  logic [2:0]  wd9_r;

  logic [8:0]  f_diff;
  logic [4:0]  dom10_nxt, dom10_r;
  logic [13:0] yr10_nxt, yr10_r;
  logic [3:0]  mon10_nxt, mon10_r;
  logic [2:0]  wd10_r;

  always_comb begin
    a_num   = {days, 2'b00} + 24'd102032;
    a_prod  = 48'(a_num) * 48'(A_RECIP);
    a5_nxt  = a_prod[47:41] + 7'd15;
    wd_num  = 23'(days) + 23'd3;
    wd_prod = 45'(wd_num) * 45'(WD_RECIP);

    b6_nxt  = 23'(days5_r) + 23'd2442113 + 23'(a5_r) - 23'(a5_r >> 2);
    // The remainder is below eight, so three bits of the difference suffice.
    wd6_nxt = 3'(wn5_r - 3'(wq5_r * 3'd7)) + 3'd1;

    c_num   = {b6_r, 4'b0000} + 27'({b6_r, 2'b00}) - 27'd2442;
    c_prod  = 55'(c_num) * 55'(C_RECIP);
    c7_nxt  = c_prod[53:40];

    d_diff  = b7_r - 23'(23'(c7_r) * 23'd365) - 23'(c7_r >> 2);
    d8_nxt  = d_diff[8:0];

    e_prod  = 39'(d8_r) * 39'(E_RECIP);
    e9_nxt  = e_prod[37:34];

    f_diff    = d9_r - 9'(9'(e9_r) * 9'd30) - 9'(month_frac(e9_r));
    dom10_nxt = f_diff[4:0];
    if (e9_r <= 4'd13) begin
      yr10_nxt  = c9_r - 14'd4716;
      mon10_nxt = e9_r - 4'd1;
    end else begin
      yr10_nxt  = c9_r - 14'd4715;
      mon10_nxt = e9_r - 4'd13;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      a5_r    <= a5_nxt;
      wq5_r   <= wd_prod[27:25];
      wn5_r   <= wd_num[2:0];
      days5_r <= days;
    end
    if (en[5]) begin
      b6_r  <= b6_nxt;
      wd6_r <= wd6_nxt;
    end
    if (en[6]) begin
      c7_r  <= c7_nxt;
      b7_r  <= b6_r;
      wd7_r <= wd6_r;
    end
    if (en[7]) begin
      d8_r  <= d8_nxt;
      c8_r  <= c7_r;
      wd8_r <= wd7_r;
    end
    if (en[8]) begin
      e9_r  <= e9_nxt;
      d9_r  <= d8_r;
      c9_r  <= c8_r;
      wd9_r <= wd8_r;
    end
    if (en[9]) begin
      yr10_r  <= yr10_nxt;
      mon10_r <= mon10_nxt;
      dom10_r <= dom10_nxt;
      wd10_r  <= wd9_r;
    end
  end

  assign year         = yr10_r;
  assign month        = mon10_r;
  assign day_of_month = dom10_r;
  assign weekday      = wd10_r;

endmodule

[verif/millis_to_calendar_date_test.sv]
// ----------------------------------------------------------------------------
// Millisecond timestamp to calendar date: testbench
// Sends Unix millisecond timestamps through the stream input and checks each
// returned word against a cycle-free prediction of the date, weekday and time
// of day. Directed checks cover the epoch, every weekday, leap and century
// years and clamping past year 9999. Random timestamps follow, with bursts of
// idle cycles on both channels and a final stretch at full rate.
// ----------------------------------------------------------------------------
module millis_to_calendar_date_test;

  localparam longint unsigned DAY_MS         = 64'd86400000;
  localparam longint unsigned LAST_STAMP     = 64'd253402300799999;
  localparam int unsigned     LAST_DAY       = 2932896;
  localparam int unsigned     DRAIN_CYCLES   = 20;
  localparam int unsigned     WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  msec;
  } cal_date_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  cal_date_t   pending_dates[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_idling    = 1'b1;
  bit          rx_idling    = 1'b1;

  millis_to_calendar_date u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The day count is turned into a date by the Julian-day integer method, and
  // the weekday by Zeller's congruence with Monday as one.
  function automatic cal_date_t calendar_of(logic [47:0] stamp);
    longint unsigned t, a, b, c, d, e, f, y, m, hi, lo, h;
    cal_date_t r;
    t = stamp;
    if (t > LAST_STAMP) begin
      t = LAST_STAMP;
    end
    r.msec   = 10'(t % 1000);
    t        = t / 1000;
    r.second = 6'(t % 60);
    t        = t / 60;
    r.minute = 6'(t % 60);
    t        = t / 60;
    r.hour   = 5'(t % 24);
    t        = t / 24;
    a = (4 * t + 102032) / 146097 + 15;
    b = t + 2442113 + a - a / 4;
    c = (20 * b - 2442) / 7305;
    d = b - 365 * c - c / 4;
    e = (d * 1000) / 30601;
    f = d - e * 30 - (e * 601) / 1000;
    if (e <= 13) begin
      c = c - 4716;
      e = e - 1;
    end else begin
      c = c - 4715;
      e = e - 13;
    end
    r.year  = 14'(c);
    r.month = 4'(e);
    r.mday  = 5'(f);
    y = c;
    m = e;
    if (m <= 2) begin
      m = m + 12;
      y = y - 1;
    end
    hi = y / 100;
    lo = y % 100;
    h  = f + (26 * (m + 1)) / 10 + lo + lo / 4 + 5 * hi + hi / 4;
    r.wday = 3'((h + 5) % 7 + 1);
    return r;
  endfunction

  function automatic logic [47:0] stamp_at(int unsigned day, longint unsigned ms_of_day);
    return 48'(longint'(day) * DAY_MS + ms_of_day);
  endfunction

  function automatic logic [47:0] random_stamp();
    longint unsigned raw;
    raw = {$urandom, $urandom};
    return 48'(raw);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance, after a random idle stretch at times.
  task automatic send_stamp(logic [47:0] stamp);
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_dates.push_back(calendar_of(stamp));
    @(negedge clk);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    cal_date_t want;
    bit        in_fire;
    bit        out_fire;
    in_fire  = rst_n && in_tvalid && in_tready === 1'b1;
    out_fire = rst_n && out_tvalid === 1'b1 && out_tready;
    if (out_fire) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected word on output: %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year",         want.year,   out_tdata[13:0]);
        check_field("month",        want.month,  out_tdata[17:14]);
        check_field("day_of_month", want.mday,   out_tdata[22:18]);
        check_field("weekday",      want.wday,   out_tdata[25:23]);
        check_field("hour",         want.hour,   out_tdata[30:26]);
        check_field("minute",       want.minute, out_tdata[36:31]);
        check_field("second",       want.second, out_tdata[42:37]);
        check_field("millis",       want.msec,   out_tdata[52:43]);
      end
    end
    quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;
  end

  initial begin
    @(negedge rst_n or posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_idling && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Epoch is a Thursday; the following six days give every other weekday.
  task automatic test_epoch_and_weekdays();
    send_stamp(48'd0);
    for (int unsigned day = 1; day < 7; day++) begin
      send_stamp(stamp_at(day, $urandom_range(0, 86399999)));
    end
    send_stamp(stamp_at(0, DAY_MS - 1));
  endtask

  task automatic test_calendar_edges();
    send_stamp(stamp_at(10957, 0) - 48'd1);
    send_stamp(stamp_at(11016, 43200000));
    send_stamp(stamp_at(11017, 0));
    send_stamp(stamp_at(47540, DAY_MS - 1));
    send_stamp(stamp_at(47541, 0));
    send_stamp(stamp_at(157366, 12345));
    send_stamp(stamp_at(157367, 0));
    send_stamp(stamp_at(730, DAY_MS - 1));
    send_stamp(stamp_at(789, 0));
  endtask

  task automatic test_clamp_past_9999();
    send_stamp(48'(LAST_STAMP - 1));
    send_stamp(48'(LAST_STAMP));
    send_stamp(48'(LAST_STAMP + 1));
    send_stamp(48'h8000_0000_0000);
    send_stamp(48'hFFFF_FFFF_FFFF);
  endtask

  task automatic test_random_stamps(int unsigned count);
    int unsigned     pick;
    longint unsigned raw;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        tx_idling = $urandom_range(0, 3) != 0;
        rx_idling = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 19);
      raw  = random_stamp();
      if (pick < 10) begin
        send_stamp(48'(raw % (LAST_STAMP + 1)));
      end else if (pick < 14) begin
        send_stamp(stamp_at($urandom_range(0, LAST_DAY),
                            $urandom_range(0, 1) ? $urandom_range(0, 999)
                                                 : DAY_MS - 1 - $urandom_range(0, 999)));
      end else if (pick < 17) begin
        send_stamp(stamp_at($urandom_range(0, 1500), $urandom_range(0, 86399999)));
      end else begin
        send_stamp(48'(LAST_STAMP + 1 + raw % (64'hFFFF_FFFF_FFFF - LAST_STAMP)));
      end
    end
  endtask

  task automatic test_full_rate(int unsigned count);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      send_stamp(48'(random_stamp() % (LAST_STAMP + 1)));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_epoch_and_weekdays();
    test_calendar_edges();
    test_clamp_past_9999();
    test_random_stamps(1050);
    test_full_rate(150);
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
